### design/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg: keypad scanner shared definitions
// Matrix geometry, counter widths, configuration register indexes and the
// control bundle handed from the scan sequencer to the counter update unit.
// ----------------------------------------------------------------------------
package kpd_pkg;

   localparam int MAX_ROWS  = 4;
   localparam int MAX_COLS  = 4;
   localparam int NUM_KEYS  = MAX_ROWS * MAX_COLS;
   localparam int LEVEL_W   = 16;
   localparam int CODE_W    = 5;
   localparam int CNT_W     = 8;
   localparam int CFG_W     = 8;
   localparam int CSR_IDX_W = 2;
   localparam int DIM_W     = 3;
   localparam int STEP_W    = $clog2(NUM_KEYS);
   localparam int ROW_W     = $clog2(MAX_ROWS + 1);
   localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int LVL_SUM_W = 8;
   localparam int LVL_IDX_W = $clog2(LEVEL_W);

   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(200);
   localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSED_LEVEL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS = 2'd3;

   typedef struct packed {
      logic             active;   // this key is scanned on this tick
      logic             pressed;  // sampled level matches the pressed level
      logic [CNT_W-1:0] thr;      // debounce threshold
   } upd_ctrl_type;

endpackage

### design/matrix_keypad_debounce_scanner.sv
// ----------------------------------------------------------------------------
// matrix_keypad_debounce_scanner: matrix keypad scanner with debounce
// One request word is one scan tick; the response word carries the code of
// the first key whose debounce counter reaches the threshold, or 0.
// ----------------------------------------------------------------------------
// The sixteen-cell counter ring makes one full turn per tick, one counter
//   through the update unit per cycle, but the last step of a tick waits
//   until the response register can take the result.
// A new request is taken in the last cycle of the current tick.
// Reset (synchronous): counters cleared, registers to pressed level 0,
//   4 rows, 4 columns, threshold 200; no clearing pass is needed.
// ----------------------------------------------------------------------------
module matrix_keypad_debounce_scanner (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kpd_pkg::LEVEL_W-1:0]   req_key_levels,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kpd_pkg::CODE_W-1:0]    rsp_key_code,
   // configuration write port
   input  logic                          csr_write,
   input  logic [kpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kpd_pkg::CFG_W-1:0]     csr_wdata
);

   localparam logic [kpd_pkg::STEP_W-1:0] LAST_STEP = kpd_pkg::STEP_W'(kpd_pkg::NUM_KEYS - 1);

   // configuration registers
   logic                         pressed_level_ff;
   logic [kpd_pkg::DIM_W-1:0]    rows_ff;
   logic [kpd_pkg::DIM_W-1:0]    cols_ff;
   logic [kpd_pkg::CNT_W-1:0]    thr_ff;

   // scan sequencer
   logic                         busy_ff, busy_in;
   logic [kpd_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [kpd_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [kpd_pkg::COL_W-1:0]    col_ff, col_in;
   logic                         done_ff, done_in;
   logic [kpd_pkg::CODE_W-1:0]   code_ff, code_in;
   logic [kpd_pkg::LEVEL_W-1:0]  levels_ff, levels_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [kpd_pkg::CODE_W-1:0]   rsp_code_ff, rsp_code_in;

   logic                         slot_free, advance, finish, accept;
   logic [kpd_pkg::DIM_W-1:0]    rows_eff, cols_eff;
   logic                         col_wrap;
   logic [kpd_pkg::LVL_SUM_W-1:0] lvl_sum;
   logic                         key_level;
   logic [kpd_pkg::CODE_W-1:0]   step_code;

   kpd_pkg::upd_ctrl_type        upd_ctrl;
   logic [kpd_pkg::CNT_W-1:0]    upd_cnt;
   logic                         upd_hit;
   logic [kpd_pkg::CNT_W-1:0]    ring_q [kpd_pkg::NUM_KEYS];
   logic [kpd_pkg::CNT_W-1:0]    ring_d [kpd_pkg::NUM_KEYS];

   // ---------------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_level_ff <= 1'b0;
         rows_ff          <= kpd_pkg::DIM_W'(4);
         cols_ff          <= kpd_pkg::DIM_W'(4);
         thr_ff           <= kpd_pkg::DEBOUNCE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            kpd_pkg::CSR_PRESSED_LEVEL:  pressed_level_ff <= csr_wdata[0];
            kpd_pkg::CSR_ROWS_IN_USE:    rows_ff <= csr_wdata[kpd_pkg::DIM_W-1:0];
            kpd_pkg::CSR_COLS_IN_USE:    cols_ff <= csr_wdata[kpd_pkg::DIM_W-1:0];
            kpd_pkg::CSR_DEBOUNCE_TICKS: thr_ff <= csr_wdata[kpd_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // counts beyond the matrix fall back to the matrix size
   assign rows_eff = (rows_ff > kpd_pkg::DIM_W'(kpd_pkg::MAX_ROWS)) ?
                     kpd_pkg::DIM_W'(kpd_pkg::MAX_ROWS) : rows_ff;
   assign cols_eff = (cols_ff > kpd_pkg::DIM_W'(kpd_pkg::MAX_COLS)) ?
                     kpd_pkg::DIM_W'(kpd_pkg::MAX_COLS) : cols_ff;

   // ---------------------------------------------------------------------
   // handshake
   // ---------------------------------------------------------------------
   // The last step of a tick only retires when the output register can
   // take the result; a new word is then accepted in that same cycle.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign advance   = busy_ff && ((step_ff != LAST_STEP) || slot_free);
   assign finish    = advance && (step_ff == LAST_STEP);
   assign req_ready = !busy_ff || finish;
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // scan position: step is the packed counter index cols*row+col, the
   // level bit uses the fixed matrix stride
   // ---------------------------------------------------------------------
   assign lvl_sum = kpd_pkg::LVL_SUM_W'(row_ff) * kpd_pkg::LVL_SUM_W'(kpd_pkg::MAX_COLS)
                    + kpd_pkg::LVL_SUM_W'(col_ff);
   assign key_level = (lvl_sum < kpd_pkg::LVL_SUM_W'(kpd_pkg::LEVEL_W)) ?
                      levels_ff[lvl_sum[kpd_pkg::LVL_IDX_W-1:0]] : 1'b0;

   assign upd_ctrl.active  = busy_ff && !done_ff && (rows_eff != '0) && (cols_eff != '0)
                             && (kpd_pkg::DIM_W'(row_ff) < rows_eff);
   assign upd_ctrl.pressed = (key_level == pressed_level_ff);
   assign upd_ctrl.thr     = thr_ff;

   assign step_code = kpd_pkg::CODE_W'(step_ff) + kpd_pkg::CODE_W'(1);
   assign col_wrap  = (kpd_pkg::DIM_W'(col_ff) + kpd_pkg::DIM_W'(1)) == cols_eff;

   always_comb begin
      busy_in   = busy_ff;
      step_in   = step_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      done_in   = done_ff;
      code_in   = code_ff;
      levels_in = levels_ff;
      if (advance) begin
         step_in = step_ff + kpd_pkg::STEP_W'(1);
         if (col_wrap) begin
            col_in = '0;
            // hold the row once past the last row in use
            if (kpd_pkg::DIM_W'(row_ff) != rows_eff) begin
               row_in = row_ff + kpd_pkg::ROW_W'(1);
            end
         end else begin
            col_in = col_ff + kpd_pkg::COL_W'(1);
         end
         if (upd_hit) begin
            done_in = 1'b1;
            code_in = step_code;
         end
         if (finish) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in   = 1'b1;
         step_in   = '0;
         row_in    = '0;
         col_in    = '0;
         done_in   = 1'b0;
         code_in   = '0;
         levels_in = req_key_levels;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
         done_ff <= 1'b0;
         code_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         done_ff <= done_in;
         code_ff <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      levels_ff <= levels_in;
   end

   // ---------------------------------------------------------------------
   // counter ring: cell 0 always holds the counter of the current step;
   // its updated value re-enters at the far end, so after a full turn
   // every counter is back at its home cell.
   // ---------------------------------------------------------------------
   kpd_update u_update (
      .ctrl     (upd_ctrl),
      .cnt_cur  (ring_q[0]),
      .cnt_next (upd_cnt),
      .hit      (upd_hit)
   );

   for (genvar g = 0; g < kpd_pkg::NUM_KEYS; g++) begin : g_ring
      if (g == kpd_pkg::NUM_KEYS - 1) begin : g_tail
         assign ring_d[g] = upd_cnt;
      end else begin : g_link
         assign ring_d[g] = ring_q[g+1];
      end
      kpd_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (advance),
         .cnt_nbr (ring_d[g]),
         .cnt_out (ring_q[g])
      );
   end

   // ---------------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = upd_hit ? step_code : code_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_code = rsp_code_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_ring_home: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (step_ff == '0))
      else $error("counter ring not aligned while idle");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff && (step_ff == LAST_STEP)))
      else $error("response raised outside the last scan step");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_code_ff <= kpd_pkg::CODE_W'(kpd_pkg::NUM_KEYS)))
      else $error("key code beyond the matrix");

   a_done_code: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && done_ff) |-> (code_ff != '0))
      else $error("reported key without a code");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (row_ff <= kpd_pkg::ROW_W'(kpd_pkg::MAX_ROWS)))
      else $error("row position ran past the matrix");

endmodule

### design/kpd_cell.sv
// ----------------------------------------------------------------------------
// kpd_cell: one debounce counter of the rotating counter ring
// Holds one key's counter and passes it to its neighbor on every shift.
// ----------------------------------------------------------------------------
module kpd_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift,
   input  logic [kpd_pkg::CNT_W-1:0] cnt_nbr,
   output logic [kpd_pkg::CNT_W-1:0] cnt_out
);

   logic [kpd_pkg::CNT_W-1:0] cnt_ff;
   logic [kpd_pkg::CNT_W-1:0] cnt_in;

   assign cnt_in  = shift ? cnt_nbr : cnt_ff;
   assign cnt_out = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

### design/kpd_update.sv
// ----------------------------------------------------------------------------
// kpd_update: debounce counter update
// Counts a pressed key up to threshold plus one (255 at most), clears a
// released key, and flags a counter that lands on the threshold.
// ----------------------------------------------------------------------------
module kpd_update (
   input  kpd_pkg::upd_ctrl_type     ctrl,
   input  logic [kpd_pkg::CNT_W-1:0] cnt_cur,
   output logic [kpd_pkg::CNT_W-1:0] cnt_next,
   output logic                      hit
);

   logic below_top;
   logic [kpd_pkg::CNT_W-1:0] cnt_upd;

   // saturation point is thr+1, capped at the counter's full scale
   assign below_top = (ctrl.thr == kpd_pkg::CNT_MAX) ? (cnt_cur != kpd_pkg::CNT_MAX)
                                                       : (cnt_cur <= ctrl.thr);

   always_comb begin
      if (ctrl.pressed) begin
         cnt_upd = below_top ? cnt_cur + kpd_pkg::CNT_W'(1) : cnt_cur;
      end else begin
         cnt_upd = '0;
      end
   end

   assign cnt_next = ctrl.active ? cnt_upd : cnt_cur;
   assign hit      = ctrl.active && (cnt_upd == ctrl.thr);

endmodule

### test/matrix_keypad_debounce_scanner_tb.sv
// ----------------------------------------------------------------------------
// matrix_keypad_debounce_scanner_tb: self-checking bench for the keypad scanner
// Drives scan-tick words with random pacing on both channels, reprograms the
// scanner between phases and compares every response word against a
// per-key debounce counter predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
module matrix_keypad_debounce_scanner_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow copy of the registers and of the press counters.
   // Each accepted request word is scanned right away; the resulting key
   // code waits in a queue for the matching response word.
   // -------------------------------------------------------------------------
   class keypad_scoreboard;
      logic                       pressed_lvl;
      logic [kpd_pkg::DIM_W-1:0]  rows_cfg;
      logic [kpd_pkg::DIM_W-1:0]  cols_cfg;
      logic [kpd_pkg::CNT_W-1:0]  thr_cfg;
      logic [kpd_pkg::CNT_W-1:0]  press_cnt [kpd_pkg::NUM_KEYS];
      logic [kpd_pkg::CODE_W-1:0] code_q [$];
      int errors;
      int words_seen;

      function new();
         pressed_lvl = 1'b0;
         rows_cfg    = kpd_pkg::DIM_W'(kpd_pkg::MAX_ROWS);
         cols_cfg    = kpd_pkg::DIM_W'(kpd_pkg::MAX_COLS);
         thr_cfg     = kpd_pkg::DEBOUNCE_RESET;
         foreach (press_cnt[i]) press_cnt[i] = '0;
         errors      = 0;
         words_seen  = 0;
      endfunction

      function void write_reg(logic [kpd_pkg::CSR_IDX_W-1:0] idx,
                              logic [kpd_pkg::CFG_W-1:0] val);
         case (idx)
            kpd_pkg::CSR_PRESSED_LEVEL:  pressed_lvl = val[0];
            kpd_pkg::CSR_ROWS_IN_USE:    rows_cfg    = val[kpd_pkg::DIM_W-1:0];
            kpd_pkg::CSR_COLS_IN_USE:    cols_cfg    = val[kpd_pkg::DIM_W-1:0];
            kpd_pkg::CSR_DEBOUNCE_TICKS: thr_cfg     = val[kpd_pkg::CNT_W-1:0];
            default: ;
         endcase
      endfunction

      // one scan tick; stops at the first key that hits the threshold
      function logic [kpd_pkg::CODE_W-1:0] scan_tick(logic [kpd_pkg::LEVEL_W-1:0] lv);
         int rows, cols, top, idx, cnt;
         rows = (rows_cfg > kpd_pkg::MAX_ROWS) ? kpd_pkg::MAX_ROWS : int'(rows_cfg);
         cols = (cols_cfg > kpd_pkg::MAX_COLS) ? kpd_pkg::MAX_COLS : int'(cols_cfg);
         top  = int'(thr_cfg) + 1;
         if (top > int'(kpd_pkg::CNT_MAX)) top = int'(kpd_pkg::CNT_MAX);
         for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
               idx = cols * r + c;
               if (idx >= kpd_pkg::NUM_KEYS) continue;
               cnt = press_cnt[idx];
               if (lv[r * kpd_pkg::MAX_COLS + c] == pressed_lvl) begin
                  if (cnt < top) cnt++;
               end else begin
                  cnt = 0;
               end
               press_cnt[idx] = kpd_pkg::CNT_W'(cnt);
               if (cnt == int'(thr_cfg)) return kpd_pkg::CODE_W'(idx + 1);
            end
         end
         return '0;
      endfunction

      function void note_request(logic [kpd_pkg::LEVEL_W-1:0] lv);
         code_q.push_back(scan_tick(lv));
      endfunction

      function void check_response(logic [kpd_pkg::CODE_W-1:0] code);
         logic [kpd_pkg::CODE_W-1:0] want;
         words_seen++;
         if (code_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("response word %0d unexpected: key_code %0d", words_seen, code);
            return;
         end
         want = code_q.pop_front();
         if (code !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("response word %0d: key_code expected %0d, got %0d",
                        words_seen, want, code);
         end
      endfunction

      function int pending();
         return code_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // -------------------------------------------------------------------------
   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_ready;
   logic [kpd_pkg::LEVEL_W-1:0]   req_key_levels = '0;
   logic                          rsp_valid;
   logic                          rsp_ready      = 1'b0;
   logic [kpd_pkg::CODE_W-1:0]    rsp_key_code;
   logic                          csr_write      = 1'b0;
   logic [kpd_pkg::CSR_IDX_W-1:0] csr_index      = '0;
   logic [kpd_pkg::CFG_W-1:0]     csr_wdata      = '0;

   keypad_scoreboard sb;
   int cycle_count = 0;
   int rsp_count   = 0;

   matrix_keypad_debounce_scanner dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_levels (req_key_levels),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_key_code   (rsp_key_code),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hang anywhere ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[matrix_keypad_debounce_scanner] ERROR");
         $finish;
      end
   end

   // response monitor: values read here are the pre-edge ones
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_key_code);
         rsp_count++;
      end
   end

   // -------------------------------------------------------------------------
   // Pacing helpers: mostly short idles, now and then a long one
   // -------------------------------------------------------------------------
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int send_gap(bit calm);
      if (calm || $urandom_range(0, 99) < 45) return 0;
      return idle_len();
   endfunction

   // -------------------------------------------------------------------------
   // Response side: random stalls, calm stretches, and one long hold-off
   // taken while the sender is busy so the scanner backs up into req_ready.
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int stall_left;
      int calm_left;
      int r;
      bit long_done;
      stall_left = 0;
      calm_left  = 0;
      long_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!long_done && rsp_count >= 60 && req_valid) begin
            long_done  = 1'b1;
            stall_left = 399;
            rsp_ready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
               calm_left = $urandom_range(30, 200);
               rsp_ready <= 1'b1;
            end else if (r < 30) begin
               stall_left = idle_len() - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // Offer one scan word and hold it until taken. valid only drops when a
   // gap follows, so back-to-back words never see a low/high in one step.
   task automatic send_word(input logic [kpd_pkg::LEVEL_W-1:0] lv, input int gap);
      req_valid      <= 1'b1;
      req_key_levels <= lv;
      do @(posedge clock); while (!req_ready);
      sb.note_request(lv);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Reprogram all four registers; only done once every response is back.
   // Unused high bits of the write data are randomized, the block masks them.
   task automatic set_config(input logic pl,
                             input logic [kpd_pkg::DIM_W-1:0] rows,
                             input logic [kpd_pkg::DIM_W-1:0] cols,
                             input logic [kpd_pkg::CNT_W-1:0] thr);
      logic [kpd_pkg::CFG_W-1:0]     vals [4];
      logic [kpd_pkg::CSR_IDX_W-1:0] idxs [4];
      while (sb.pending() != 0) @(posedge clock);
      idxs[0] = kpd_pkg::CSR_PRESSED_LEVEL;  vals[0] = {7'($urandom), pl};
      idxs[1] = kpd_pkg::CSR_ROWS_IN_USE;    vals[1] = {5'($urandom), rows};
      idxs[2] = kpd_pkg::CSR_COLS_IN_USE;    vals[2] = {5'($urandom), cols};
      idxs[3] = kpd_pkg::CSR_DEBOUNCE_TICKS; vals[3] = thr;
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= idxs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(idxs[i], vals[i]);
      end
      csr_write <= 1'b0;
   endtask

   // Held key patterns (what a real keypad delivers) with contact bounce
   // and the odd garbage word mixed in.
   task automatic run_stream(input int n, input int hold_max, input bit calm);
      logic [kpd_pkg::LEVEL_W-1:0] pat;
      logic [kpd_pkg::LEVEL_W-1:0] word;
      logic [kpd_pkg::LEVEL_W-1:0] one_key;
      int left;
      int r;
      pat  = '0;
      left = 0;
      for (int i = 0; i < n; i++) begin
         if (left == 0) begin
            left = $urandom_range(1, hold_max);
            if ($urandom_range(0, 99) < 35) begin
               // a single key down, the rest up
               one_key = kpd_pkg::LEVEL_W'(1) << $urandom_range(0, kpd_pkg::LEVEL_W - 1);
               pat = sb.pressed_lvl ? one_key : ~one_key;
            end else begin
               pat = kpd_pkg::LEVEL_W'($urandom);
            end
         end
         word = pat;
         r = $urandom_range(0, 99);
         if (r < 10)
            word = word ^ (kpd_pkg::LEVEL_W'(1) << $urandom_range(0, kpd_pkg::LEVEL_W - 1));
         else if (r < 14)
            word = kpd_pkg::LEVEL_W'($urandom);
         left--;
         send_word(word, send_gap(calm));
      end
      req_valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : main_seq
      int random_words;
      int n;
      int thr;
      int r;
      logic [kpd_pkg::LEVEL_W-1:0] word;
      logic [kpd_pkg::DIM_W-1:0]   rows;
      logic [kpd_pkg::DIM_W-1:0]   cols;

      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: active low, full 4x4, threshold 200
      send_word(16'h0000, send_gap(1'b0));
      send_word(16'hFFFF, send_gap(1'b0));
      send_word(16'hA5A5, 1);

      // active high, threshold 1: a key reports on its first pressed tick
      set_config(1'b1, 3'd4, 3'd4, 8'd1);
      send_word(16'h0001, 0);
      send_word(16'h0001, 0);
      send_word(16'h8000, send_gap(1'b0));
      send_word(16'hFFFF, 0);
      send_word(16'hFFFF, 1);

      // threshold zero: first released key in scan order reports
      set_config(1'b0, 3'd4, 3'd4, 8'd0);
      send_word(16'h0000, 0);
      send_word(16'h0001, 0);
      send_word(16'hFFFE, 1);

      // zero rows, then zero columns: nothing scanned
      set_config(1'b0, 3'd0, 3'd4, 8'd1);
      send_word(16'h0000, 1);
      set_config(1'b0, 3'd4, 3'd0, 8'd1);
      send_word(16'h0000, 1);

      // oversize dimensions clamp to the matrix size
      set_config(1'b1, 3'd7, 3'd7, 8'd2);
      send_word(16'hFFFF, 0);
      send_word(16'hFFFF, 0);
      send_word(16'hFFFF, 1);

      // narrower layout keeps the counters, now indexed with stride 3
      set_config(1'b1, 3'd4, 3'd3, 8'd2);
      send_word(16'hFFFF, 0);
      send_word(16'hFFFF, 1);

      // single key matrix
      set_config(1'b0, 3'd1, 3'd1, 8'd3);
      send_word(16'h0000, 0);
      send_word(16'h0000, 0);
      send_word(16'h0000, 1);

      // random phases: small thresholds so held keys report often
      random_words = 0;
      while (random_words < 250) begin
         r    = $urandom_range(0, 99);
         rows = (r < 80) ? kpd_pkg::DIM_W'($urandom_range(1, 4))
                         : kpd_pkg::DIM_W'($urandom_range(0, 7));
         r    = $urandom_range(0, 99);
         cols = (r < 80) ? kpd_pkg::DIM_W'($urandom_range(1, 4))
                         : kpd_pkg::DIM_W'($urandom_range(0, 7));
         r    = $urandom_range(0, 99);
         if (r < 50)      thr = $urandom_range(0, 3);
         else if (r < 90) thr = $urandom_range(4, 10);
         else             thr = $urandom_range(11, 40);
         set_config(1'($urandom), rows, cols, kpd_pkg::CNT_W'(thr));
         n = $urandom_range(20, 50);
         run_stream(n, thr + 4, $urandom_range(0, 3) == 0);
         random_words += n;
      end

      // deepest threshold: keys 0, 5 and 10 held through 262 ticks while the
      // other keys chatter; the first three reports come one tick apart
      set_config(1'b1, 3'd4, 3'd4, 8'd254);
      for (int i = 0; i < 262; i++) begin
         word = 16'h0421;
         if ($urandom_range(0, 3) == 0)
            word = word | (kpd_pkg::LEVEL_W'($urandom) & 16'hFBDE);
         send_word(word, send_gap(i >= 100 && i < 200));
      end
      req_valid <= 1'b0;

      // threshold 255: saturated counters stay at the threshold, so a held
      // key reports every tick; dropping key 0 hands over to key 5
      set_config(1'b1, 3'd4, 3'd4, 8'd255);
      for (int i = 0; i < 20; i++) begin
         word = 16'h0421;
         if ($urandom_range(0, 3) == 0)
            word = word ^ (kpd_pkg::LEVEL_W'(1) << $urandom_range(0, 15));
         send_word(word, send_gap(1'b0));
      end
      req_valid <= 1'b0;

      // drain, then keep watching for stray words before the verdict
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[matrix_keypad_debounce_scanner] OK");
      end else begin
         $display("[matrix_keypad_debounce_scanner] ERROR");
      end
      $finish;
   end

endmodule

### files.f
design/kpd_pkg.sv
design/kpd_cell.sv
design/kpd_update.sv
design/matrix_keypad_debounce_scanner.sv
test/matrix_keypad_debounce_scanner_tb.sv
